### rtl/gbds_pkg.sv
`timescale 1ns / 1ps

package gbds_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LIMIT     = 2'd1;

    localparam int THRESHOLD_W    = 8;
    localparam int RESULT_LIMIT_W = 11;
    localparam int KEPT_COUNT_W   = 11;

    localparam logic [THRESHOLD_W-1:0]    THR_RESET   = 8'd128;
    localparam logic [THRESHOLD_W-1:0]    THR_LOW     = 8'd13;
    localparam logic [THRESHOLD_W-1:0]    THR_HIGH    = 8'd230;
    localparam logic [RESULT_LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    // overlap ratio is in 1/256 units
    localparam int IOU_SHIFT = 8;
    // centre test: 100*d^2 <= 49*s^2 on doubled centres
    localparam int CTR_SCALE_D = 100;
    localparam int CTR_SCALE_S = 49;

    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic pipe_empty;
        logic out_free;
        logic keep_ok;
    } status_t;

endpackage

### rtl/gbds_ctrl.sv
`timescale 1ns / 1ps

module gbds_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gbds_pkg::status_t status,
    output gbds_pkg::cmd_t    cmd
);
    import gbds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // wait here while the previous result is still unclaimed
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/gbds_datapath.sv
`timescale 1ns / 1ps

module gbds_datapath #(
    parameter int MAX_KEPT   = 1024,
    parameter int COORD_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  gbds_pkg::cmd_t                         cmd,
    output gbds_pkg::status_t                      status,
    input  logic [gbds_pkg::THRESHOLD_W-1:0]       thr_cfg,
    input  logic [gbds_pkg::RESULT_LIMIT_W-1:0]    limit_cfg,
    input  logic                                   new_frame,
    input  logic [COORD_BITS-1:0]                  box_left,
    input  logic [COORD_BITS-1:0]                  box_top,
    input  logic [COORD_BITS:0]                    box_width,
    input  logic [COORD_BITS:0]                    box_height,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic                                   kept,
    output logic                                   limit_reached,
    output logic [gbds_pkg::KEPT_COUNT_W-1:0]      kept_count,
    output logic [$clog2(MAX_KEPT+1)-1:0]          total_cnt
);
    import gbds_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int LW = (CW > RESULT_LIMIT_W) ? CW : RESULT_LIMIT_W;
    localparam int EW = 4 * C + 2;
    localparam int NSTAGE = 5;

    // clamped configuration
    logic [THRESHOLD_W-1:0] thr_used;
    logic [LW-1:0]          lim_ext;
    logic [CW-1:0]          limit_used;

    always_comb
    begin
        if (thr_cfg < THR_LOW)
            thr_used = THR_LOW;
        else if (thr_cfg > THR_HIGH)
            thr_used = THR_HIGH;
        else
            thr_used = thr_cfg;

        lim_ext = LW'(limit_cfg);
        if (lim_ext == '0)
            lim_ext = LW'(1);
        else if (lim_ext > LW'(MAX_KEPT))
            lim_ext = LW'(MAX_KEPT);
        limit_used = lim_ext[CW-1:0];
    end

    // candidate and list state
    logic [EW-1:0]     cand_reg;
    logic [CW-1:0]     total_reg;
    logic [CW-1:0]     issue_reg;
    logic              dup_reg;
    logic [NSTAGE-1:0] valid_reg;

    logic [EW-1:0] mem [MAX_KEPT];
    logic [EW-1:0] mem_q_reg;

    logic issue_possible;
    logic issue_en;
    logic keep_ok;
    logic hit;

    assign issue_possible = !dup_reg && (issue_reg != total_reg) && (total_reg < limit_used);
    assign issue_en       = cmd.scan && issue_possible;
    assign keep_ok        = !dup_reg && (total_reg < limit_used);

    always_ff @(posedge clk)
    begin
        if (cmd.commit && keep_ok)
        begin
            mem[total_reg[AW-1:0]] <= cand_reg;
        end
        if (issue_en)
        begin
            mem_q_reg <= mem[issue_reg[AW-1:0]];
        end
    end

    // stage 1: edges, centre distances, sides
    logic [C-1:0] c_left, c_top, b_left, b_top;
    logic [C:0]   c_w, c_h, b_w, b_h;
    logic [C-1:0] ov_l, ov_t;
    logic [C+1:0] c_r, c_b, b_r, b_b, ov_r, ov_b, iw_full, ih_full;
    logic [C+1:0] cx, cy, bx, by;
    logic [C:0]   c_side, b_side;

    logic [C:0]   s1_iw_reg, s1_ih_reg, s1_bw_reg, s1_bh_reg, s1_s_reg;
    logic [C+1:0] s1_dx_reg, s1_dy_reg;
    logic [C:0]   iw, ih, side;
    logic [C+1:0] dx, dy;

    always_comb
    begin
        c_left = cand_reg[C-1:0];
        c_top  = cand_reg[2*C-1:C];
        c_w    = cand_reg[3*C:2*C];
        c_h    = cand_reg[4*C+1:3*C+1];
        b_left = mem_q_reg[C-1:0];
        b_top  = mem_q_reg[2*C-1:C];
        b_w    = mem_q_reg[3*C:2*C];
        b_h    = mem_q_reg[4*C+1:3*C+1];

        ov_l = (c_left > b_left) ? c_left : b_left;
        ov_t = (c_top > b_top) ? c_top : b_top;
        c_r  = (C+2)'(c_left) + (C+2)'(c_w);
        b_r  = (C+2)'(b_left) + (C+2)'(b_w);
        c_b  = (C+2)'(c_top) + (C+2)'(c_h);
        b_b  = (C+2)'(b_top) + (C+2)'(b_h);
        ov_r = (c_r < b_r) ? c_r : b_r;
        ov_b = (c_b < b_b) ? c_b : b_b;
        iw_full = ov_r - (C+2)'(ov_l);
        ih_full = ov_b - (C+2)'(ov_t);
        // overlap never exceeds the narrower box
        iw = (ov_r > (C+2)'(ov_l)) ? iw_full[C:0] : '0;
        ih = (ov_b > (C+2)'(ov_t)) ? ih_full[C:0] : '0;

        // doubled centres
        cx = (C+2)'({c_left, 1'b0}) + (C+2)'(c_w);
        bx = (C+2)'({b_left, 1'b0}) + (C+2)'(b_w);
        cy = (C+2)'({c_top, 1'b0}) + (C+2)'(c_h);
        by = (C+2)'({b_top, 1'b0}) + (C+2)'(b_h);
        dx = (cx > bx) ? (cx - bx) : (bx - cx);
        dy = (cy > by) ? (cy - by) : (by - cy);

        c_side = (c_w > c_h) ? c_w : c_h;
        b_side = (b_w > b_h) ? b_w : b_h;
        side   = (c_side < b_side) ? c_side : b_side;
    end

    // stage 2: products
    logic [2*C+1:0] s2_inter_reg, s2_area_c_reg, s2_area_b_reg, s2_ss_reg;
    logic [2*C+3:0] s2_dx2_reg, s2_dy2_reg;

    // stage 3: union, distance sum, scaled side
    logic [2*C+2:0] s3_uni_reg;
    logic [2*C+1:0] s3_inter_reg;
    logic [2*C+4:0] s3_dsum_reg;
    logic [2*C+7:0] s3_s49_reg;

    // stage 4: cross products
    logic [2*C+9:0]  s4_lhs_reg;
    logic [2*C+10:0] s4_rhs_reg;
    logic            s4_uni_nz_reg;
    logic [2*C+11:0] s4_d100_reg;
    logic [2*C+7:0]  s4_s49_reg;

    always_ff @(posedge clk)
    begin
        s1_iw_reg <= iw;
        s1_ih_reg <= ih;
        s1_bw_reg <= b_w;
        s1_bh_reg <= b_h;
        s1_s_reg  <= side;
        s1_dx_reg <= dx;
        s1_dy_reg <= dy;

        s2_inter_reg  <= (2*C+2)'(s1_iw_reg) * (2*C+2)'(s1_ih_reg);
        s2_area_c_reg <= (2*C+2)'(c_w) * (2*C+2)'(c_h);
        s2_area_b_reg <= (2*C+2)'(s1_bw_reg) * (2*C+2)'(s1_bh_reg);
        s2_ss_reg     <= (2*C+2)'(s1_s_reg) * (2*C+2)'(s1_s_reg);
        s2_dx2_reg    <= (2*C+4)'(s1_dx_reg) * (2*C+4)'(s1_dx_reg);
        s2_dy2_reg    <= (2*C+4)'(s1_dy_reg) * (2*C+4)'(s1_dy_reg);

        s3_uni_reg   <= (2*C+3)'(s2_area_c_reg) + (2*C+3)'(s2_area_b_reg)
                        - (2*C+3)'(s2_inter_reg);
        s3_inter_reg <= s2_inter_reg;
        s3_dsum_reg  <= (2*C+5)'(s2_dx2_reg) + (2*C+5)'(s2_dy2_reg);
        s3_s49_reg   <= (2*C+8)'(s2_ss_reg) * (2*C+8)'(CTR_SCALE_S);

        s4_lhs_reg    <= {s3_inter_reg, {IOU_SHIFT{1'b0}}};
        s4_rhs_reg    <= (2*C+11)'(thr_used) * (2*C+11)'(s3_uni_reg);
        s4_uni_nz_reg <= (s3_uni_reg != '0);
        s4_d100_reg   <= (2*C+12)'(s3_dsum_reg) * (2*C+12)'(CTR_SCALE_D);
        s4_s49_reg    <= s3_s49_reg;
    end

    logic iou_hit;
    logic ctr_hit;

    assign iou_hit = s4_uni_nz_reg && ((2*C+11)'(s4_lhs_reg) >= s4_rhs_reg);
    assign ctr_hit = (s4_s49_reg != '0) && ((2*C+12)'(s4_s49_reg) >= s4_d100_reg);
    assign hit     = valid_reg[NSTAGE-1] && (iou_hit || ctr_hit);

    // result register
    logic                    out_valid_reg;
    logic                    kept_reg;
    logic                    limit_reg;
    logic [KEPT_COUNT_W-1:0] count_reg;
    logic [CW-1:0]           total_new;
    logic [LW-1:0]           total_new_ext;

    assign total_new     = keep_ok ? (total_reg + CW'(1)) : total_reg;
    assign total_new_ext = LW'(total_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            issue_reg     <= '0;
            dup_reg       <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[NSTAGE-2:0], issue_en};
            if (cmd.load)
            begin
                issue_reg <= '0;
                dup_reg   <= 1'b0;
                if (new_frame)
                begin
                    total_reg <= '0;
                end
            end
            else
            begin
                if (issue_en)
                begin
                    issue_reg <= issue_reg + CW'(1);
                end
                if (hit)
                begin
                    dup_reg <= 1'b1;
                end
                if (cmd.commit)
                begin
                    total_reg <= total_new;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cand_reg <= {box_height, box_width, box_top, box_left};
        end
        if (cmd.commit)
        begin
            kept_reg  <= keep_ok;
            limit_reg <= (total_new >= limit_used);
            count_reg <= total_new_ext[KEPT_COUNT_W-1:0];
        end
    end

    assign status.pipe_empty = (valid_reg == '0);
    assign status.scan_done  = !issue_possible && (valid_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.keep_ok    = keep_ok;

    assign out_valid     = out_valid_reg;
    assign kept          = kept_reg;
    assign limit_reached = limit_reg;
    assign kept_count    = count_reg;
    assign total_cnt     = total_reg;

endmodule

### rtl/greedy_box_duplicate_suppression_core.sv
`timescale 1ns / 1ps

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: new_frame
//                                               tdata: box_left, box_top, box_width, box_height
// m_axis    out  m_axis_tvalid/m_axis_tready    tuser: kept, limit_reached
//                                               tdata: kept_count
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// a candidate is compared with the kept boxes in turn, with no compares when the list is empty
// or the limit is reached: one stored box is read from a single-port memory and compared per
// cycle through a five-stage pipeline; a duplicate ends the scan early, after the pipeline
// drains. the next candidate is taken only after this result is committed.
// reset clears the kept count and all control; the box memory is never cleared.
// a finished result waits in the output register while the next candidate is taken.

module greedy_box_duplicate_suppression_core #(
    parameter int MAX_KEPT   = 1024,
    parameter int COORD_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // box_left, box_top, box_width, box_height, zero pad
    input  logic [((4*COORD_BITS+2+7)/8)*8-1:0]    s_axis_tdata,
    // new_frame
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // kept_count, zero pad
    output logic [gbds_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // kept, limit_reached
    output logic [gbds_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [gbds_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [gbds_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import gbds_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int CW = $clog2(MAX_KEPT + 1);

    logic [THRESHOLD_W-1:0]    thr_reg;
    logic [RESULT_LIMIT_W-1:0] limit_reg;

    // cfg_ready is always high
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_THRESHOLD: thr_reg   <= cfg_data[THRESHOLD_W-1:0];
                CFG_IDX_LIMIT:     limit_reg <= cfg_data[RESULT_LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    cmd_t    cmd;
    status_t status;

    logic                    kept;
    logic                    limit_reached;
    logic [KEPT_COUNT_W-1:0] kept_count;
    logic [CW-1:0]           total_cnt;

    gbds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gbds_datapath #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .thr_cfg       (thr_reg),
        .limit_cfg     (limit_reg),
        .new_frame     (s_axis_tuser),
        .box_left      (s_axis_tdata[C-1:0]),
        .box_top       (s_axis_tdata[2*C-1:C]),
        .box_width     (s_axis_tdata[3*C:2*C]),
        .box_height    (s_axis_tdata[4*C+1:3*C+1]),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .kept          (kept),
        .limit_reached (limit_reached),
        .kept_count    (kept_count),
        .total_cnt     (total_cnt)
    );

    assign m_axis_tdata = OUT_TDATA_W'(kept_count);
    assign m_axis_tuser = {limit_reached, kept};

    // no comparison may still be in flight when a new candidate is taken
    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> status.pipe_empty)
        else $error("candidate taken with compares in flight");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(total_cnt) <= CW'(MAX_KEPT))
        else $error("kept total beyond list depth");

    a_keep_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && status.keep_ok |=> total_cnt == CW'($past(total_cnt) + CW'(1)))
        else $error("kept total did not advance on keep");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_axis_tvalid && (m_axis_tuser[0] == $past(status.keep_ok)))
        else $error("result transfer not presented after commit");

endmodule
